### design/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP response stream parser package
// Shared types, codes and character classes.
// ----------------------------------------------------------------------------
`default_nettype none
package hrsp_pkg;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RC_HEADER   = 3'd0,
    RC_BODY     = 3'd1,
    RC_DONE     = 3'd2,
    RC_HDR_ERR  = 3'd3,
    RC_LEN_ERR  = 3'd4,
    RC_TIMEOUT  = 3'd5,
    RC_IGNORED  = 3'd6
  } result_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_BODY   = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAILED = 3'd4
  } phase_t;

  localparam logic [3:0] ST_OK   = 4'd7;
  localparam logic [3:0] ST_FAIL = 4'd8;
  localparam logic [2:0] LV_OK   = 3'd3;
  localparam logic [2:0] LV_FAIL = 3'd4;
  localparam logic [3:0] RG_OK   = 4'd9;
  localparam logic [3:0] RG_FAIL = 4'd10;

  // classified word passed from front to back
  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    result_t     result_code;
    logic [7:0]  body_byte;
    logic [15:0] http_status;
    logic [31:0] body_length;
    logic        has_range;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic [31:0] range_size;
    logic [31:0] bytes_delivered;
  } result_item_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
           (c == 8'h0c) || (c == 8'h0d);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [31:0] dec(input logic [31:0] acc, input logic [7:0] c);
    return (acc << 3) + (acc << 1) + {28'd0, c[3:0]};
  endfunction

  function automatic logic [7:0] lit_http(input logic [2:0] i);
    case (i)
      3'd0:    return 8'h48;
      3'd1:    return 8'h54;
      3'd2:    return 8'h54;
      3'd3:    return 8'h50;
      default: return 8'h2f;
    endcase
  endfunction

  function automatic logic [7:0] lit_bytes(input logic [2:0] i);
    case (i)
      3'd0:    return 8'h62;
      3'd1:    return 8'h79;
      3'd2:    return 8'h74;
      3'd3:    return 8'h65;
      default: return 8'h73;
    endcase
  endfunction

  // "content-length"; "content-range" shares the first 8 characters
  function automatic logic [7:0] len_name_chr(input logic [3:0] i);
    case (i)
      4'd0:  return 8'h63;
      4'd1:  return 8'h6f;
      4'd2:  return 8'h6e;
      4'd3:  return 8'h74;
      4'd4:  return 8'h65;
      4'd5:  return 8'h6e;
      4'd6:  return 8'h74;
      4'd7:  return 8'h2d;
      4'd8:  return 8'h6c;
      4'd9:  return 8'h65;
      4'd10: return 8'h6e;
      4'd11: return 8'h67;
      4'd12: return 8'h74;
      default: return 8'h68;
    endcase
  endfunction

  function automatic logic [7:0] name_rng(input logic [3:0] i);
    case (i)
      4'd8:  return 8'h72;
      4'd9:  return 8'h61;
      4'd10: return 8'h6e;
      4'd11: return 8'h67;
      4'd12: return 8'h65;
      default: return len_name_chr(i);
    endcase
  endfunction

endpackage
`default_nettype wire

### design/hrsp_if.sv
// ----------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for input, result and configuration words.
// ----------------------------------------------------------------------------
`default_nettype none
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface hrsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic [7:0]  body_byte;
  logic [15:0] http_status;
  logic [31:0] body_length;
  logic        has_range;
  logic [31:0] range_first;
  logic [31:0] range_last;
  logic [31:0] range_size;
  logic [31:0] bytes_delivered;
  modport source (output valid, result_code, body_byte, http_status, body_length,
                  has_range, range_first, range_last, range_size, bytes_delivered,
                  input ready);
  modport sink (input valid, result_code, body_byte, http_status, body_length,
                has_range, range_first, range_last, range_size, bytes_delivered,
                output ready);
endinterface

interface hrsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### design/hrsp_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue between the front and the back of the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module hrsp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hrsp_pkg::item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hrsp_pkg::item_t    out_item
);
  import hrsp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/hrsp_back.sv
// ----------------------------------------------------------------------------
// Parser back end
// Runs header parsing and body counting, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module hrsp_back #(
  parameter int HEADER_COUNT_WIDTH = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [11:0]        header_limit,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hrsp_pkg::item_t    in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hrsp_pkg::result_item_t  out_item
);
  import hrsp_pkg::*;

  localparam logic [HEADER_COUNT_WIDTH-1:0] CMAX = '1;

  phase_t phase, phase_next;
  logic [HEADER_COUNT_WIDTH-1:0] header_bytes, header_bytes_next;
  logic [1:0]  term, term_next;
  logic        line_start, line_start_next;
  logic [3:0]  st_step, st_step_next;
  logic [2:0]  st_lit, st_lit_next;
  logic [4:0]  name_pos, name_pos_next;
  logic [1:0]  cand, cand_next;
  logic [2:0]  value_step, value_step_next;
  logic [3:0]  rg_step, rg_step_next;
  logic [2:0]  rg_lit, rg_lit_next;
  logic [15:0] status_acc, status_acc_next;
  logic [31:0] length_acc, length_acc_next;
  logic [31:0] rf_acc, rf_acc_next;
  logic [31:0] rl_acc, rl_acc_next;
  logic [31:0] rs_acc, rs_acc_next;
  logic        has_range, has_range_next;
  logic [31:0] body_count, body_count_next;
  result_t     code;
  logic [7:0]  bb;
  logic        take;
  logic        out_full;
  logic [31:0] status_dec;
  logic [31:0] body_inc;
  logic [7:0]  b, lc;
  logic [1:0]  cand_mid;
  logic [15:0] hb_wide;
  logic        limit_hit;

  assign in_ready = !out_full || out_ready;
  assign take     = in_valid && in_ready;
  assign b        = in_item.rx_byte;
  assign lc       = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  assign status_dec = dec({16'd0, status_acc}, b);
  assign body_inc   = body_count + 32'd1;

  assign hb_wide   = 16'(header_bytes);
  assign limit_hit = hb_wide >= {4'd0, header_limit};

  always_comb begin
    phase_next = phase;
    header_bytes_next = header_bytes;
    term_next = term;
    line_start_next = line_start;
    st_step_next = st_step;
    st_lit_next = st_lit;
    name_pos_next = name_pos;
    cand_next = cand;
    cand_mid = cand;
    value_step_next = value_step;
    rg_step_next = rg_step;
    rg_lit_next = rg_lit;
    status_acc_next = status_acc;
    length_acc_next = length_acc;
    rf_acc_next = rf_acc;
    rl_acc_next = rl_acc;
    rs_acc_next = rs_acc;
    has_range_next = has_range;
    body_count_next = body_count;
    code = RC_IGNORED;
    bb = 8'd0;
    unique case (in_item.action)
      ACT_START: begin
        phase_next = PH_HEADER;
        header_bytes_next = '0;
        term_next = 2'd0;
        line_start_next = 1'b1;
        st_step_next = 4'd0;
        st_lit_next = 3'd0;
        name_pos_next = 5'd0;
        cand_next = 2'b11;
        value_step_next = 3'd0;
        rg_step_next = 4'd0;
        rg_lit_next = 3'd0;
        status_acc_next = 16'd0;
        length_acc_next = 32'd0;
        rf_acc_next = 32'd0;
        rl_acc_next = 32'd0;
        rs_acc_next = 32'd0;
        has_range_next = 1'b0;
        body_count_next = 32'd0;
        code = RC_HEADER;
      end
      ACT_TIMEOUT: begin
        if (phase == PH_HEADER || phase == PH_BODY) begin
          phase_next = PH_FAILED;
          code = RC_TIMEOUT;
        end
      end
      ACT_BYTE: begin
        if (phase == PH_HEADER) begin
          if (limit_hit) begin
            phase_next = PH_FAILED;
            code = RC_HDR_ERR;
          end else begin
            code = RC_HEADER;
            if (header_bytes != CMAX) header_bytes_next = header_bytes + 1'b1;
            // status line
            case (st_step)
              4'd0: begin
                if (b == lit_http(st_lit)) begin
                  st_lit_next = st_lit + 3'd1;
                  if (st_lit == 3'd4) st_step_next = 4'd1;
                end else st_step_next = ST_FAIL;
              end
              4'd1: if (is_dig(b)) st_step_next = 4'd2;
                    else if (!is_ws(b)) st_step_next = ST_FAIL;
              4'd2: if (b == 8'h2e) st_step_next = 4'd3;
                    else if (!is_dig(b)) st_step_next = ST_FAIL;
              4'd3: if (is_dig(b)) st_step_next = 4'd4;
                    else if (!is_ws(b)) st_step_next = ST_FAIL;
              4'd4: if (is_ws(b)) st_step_next = 4'd5;
                    else if (!is_dig(b)) st_step_next = ST_FAIL;
              4'd5: begin
                if (is_dig(b)) begin
                  status_acc_next = {12'd0, b[3:0]};
                  st_step_next = 4'd6;
                end else if (!is_ws(b)) st_step_next = ST_FAIL;
              end
              4'd6: if (is_dig(b)) status_acc_next = status_dec[15:0];
                    else st_step_next = ST_OK;
              default: ;
            endcase
            // content length value
            if (value_step == 3'd1) begin
              if (is_dig(b)) begin
                length_acc_next = {28'd0, b[3:0]};
                value_step_next = 3'd2;
              end else if (!is_ws(b)) value_step_next = LV_FAIL;
            end else if (value_step == 3'd2) begin
              if (is_dig(b)) length_acc_next = dec(length_acc, b);
              else value_step_next = LV_OK;
            end
            // content range value
            case (rg_step)
              4'd1: begin
                if (b == 8'h62) begin
                  rg_lit_next = 3'd1;
                  rg_step_next = 4'd2;
                end else if (b != 8'h20 && b != 8'h09) rg_step_next = RG_FAIL;
              end
              4'd2: begin
                if (b == lit_bytes(rg_lit)) begin
                  rg_lit_next = rg_lit + 3'd1;
                  if (rg_lit == 3'd4) rg_step_next = 4'd3;
                end else rg_step_next = RG_FAIL;
              end
              4'd3: begin
                if (is_dig(b)) begin
                  rf_acc_next = {28'd0, b[3:0]};
                  rg_step_next = 4'd4;
                end else if (!is_ws(b)) rg_step_next = RG_FAIL;
              end
              4'd4: if (is_dig(b)) rf_acc_next = dec(rf_acc, b);
                    else rg_step_next = (b == 8'h2d) ? 4'd5 : RG_FAIL;
              4'd5: begin
                if (is_dig(b)) begin
                  rl_acc_next = {28'd0, b[3:0]};
                  rg_step_next = 4'd6;
                end else if (!is_ws(b)) rg_step_next = RG_FAIL;
              end
              4'd6: if (is_dig(b)) rl_acc_next = dec(rl_acc, b);
                    else rg_step_next = (b == 8'h2f) ? 4'd7 : RG_FAIL;
              4'd7: begin
                if (is_dig(b)) begin
                  rs_acc_next = {28'd0, b[3:0]};
                  rg_step_next = 4'd8;
                end else if (!is_ws(b)) rg_step_next = RG_FAIL;
              end
              4'd8: if (is_dig(b)) rs_acc_next = dec(rs_acc, b);
                    else rg_step_next = RG_OK;
              default: ;
            endcase
            // header names
            if (line_start) begin
              cand_mid = 2'b11;
              name_pos_next = 5'd0;
              line_start_next = 1'b0;
            end
            cand_next = cand_mid;
            if (cand_mid[0]) begin
              if (!line_start && name_pos >= 5'd14) begin
                cand_next[0] = 1'b0;
                if (b == 8'h3a && value_step == 3'd0) value_step_next = 3'd1;
              end else if (lc != len_name_chr(line_start ? 4'd0 : name_pos[3:0])) begin
                cand_next[0] = 1'b0;
              end
            end
            if (cand_mid[1]) begin
              if (!line_start && name_pos >= 5'd13) begin
                cand_next[1] = 1'b0;
                if (b == 8'h3a && rg_step == 4'd0) rg_step_next = 4'd1;
              end else if (lc != name_rng(line_start ? 4'd0 : name_pos[3:0])) begin
                cand_next[1] = 1'b0;
              end
            end
            if (line_start) name_pos_next = 5'd1;
            else if (name_pos < 5'd31) name_pos_next = name_pos + 5'd1;
            // terminator
            if (b == 8'h0d) begin
              term_next = (term == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == 8'h0a) begin
              if (term == 2'd3) begin
                term_next = 2'd0;
                if (st_step_next != 4'd6 && st_step_next != ST_OK) begin
                  phase_next = PH_FAILED;
                  code = RC_HDR_ERR;
                end else if (value_step_next != 3'd2 && value_step_next != LV_OK) begin
                  phase_next = PH_FAILED;
                  code = RC_LEN_ERR;
                end else if (rg_step_next != 4'd0 && rg_step_next != 4'd8 &&
                             rg_step_next != RG_OK) begin
                  phase_next = PH_FAILED;
                  code = RC_HDR_ERR;
                end else begin
                  if (rg_step_next != 4'd0) has_range_next = 1'b1;
                  if (length_acc_next == 32'd0) begin
                    phase_next = PH_DONE;
                    code = RC_DONE;
                  end else phase_next = PH_BODY;
                end
              end else if (term == 2'd1) begin
                term_next = 2'd2;
                line_start_next = 1'b1;
              end else term_next = 2'd0;
            end else begin
              term_next = 2'd0;
            end
          end
        end else if (phase == PH_BODY) begin
          body_count_next = body_inc;
          bb = b;
          if (body_inc == length_acc) begin
            phase_next = PH_DONE;
            code = RC_DONE;
          end else code = RC_BODY;
        end else if (phase == PH_DONE) begin
          phase_next = PH_FAILED;
          code = RC_LEN_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      header_bytes <= '0;
      term <= 2'd0;
      line_start <= 1'b1;
      st_step <= 4'd0;
      st_lit <= 3'd0;
      name_pos <= 5'd0;
      cand <= 2'b11;
      value_step <= 3'd0;
      rg_step <= 4'd0;
      rg_lit <= 3'd0;
      status_acc <= 16'd0;
      length_acc <= 32'd0;
      rf_acc <= 32'd0;
      rl_acc <= 32'd0;
      rs_acc <= 32'd0;
      has_range <= 1'b0;
      body_count <= 32'd0;
      out_full <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        header_bytes <= header_bytes_next;
        term <= term_next;
        line_start <= line_start_next;
        st_step <= st_step_next;
        st_lit <= st_lit_next;
        name_pos <= name_pos_next;
        cand <= cand_next;
        value_step <= value_step_next;
        rg_step <= rg_step_next;
        rg_lit <= rg_lit_next;
        status_acc <= status_acc_next;
        length_acc <= length_acc_next;
        rf_acc <= rf_acc_next;
        rl_acc <= rl_acc_next;
        rs_acc <= rs_acc_next;
        has_range <= has_range_next;
        body_count <= body_count_next;
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.result_code <= code;
      out_item.body_byte <= bb;
      out_item.http_status <= status_acc_next;
      out_item.body_length <= length_acc_next;
      out_item.has_range <= has_range_next;
      out_item.range_first <= rf_acc_next;
      out_item.range_last <= rl_acc_next;
      out_item.range_size <= rs_acc_next;
      out_item.bytes_delivered <= body_count_next;
    end
  end

  assign out_valid = out_full;
endmodule
`default_nettype wire

### design/http_response_stream_parser.sv
// ----------------------------------------------------------------------------
// HTTP response stream parser
// Parses response headers byte by byte and passes the body through.
// ----------------------------------------------------------------------------
// One input word per cycle sustained unless the result side stalls, one result
// word per input word; each word is registered in the input queue and then in
// the result register. All header parsing of a byte is done in one pass of the
// back end's update logic.
// Write header_limit only while no words are in flight.
`default_nettype none
module http_response_stream_parser #(
  parameter int HEADER_COUNT_WIDTH = 12
) (
  input wire logic   clk,
  input wire logic   rst,
  hrsp_in_if.sink    in_ch,
  hrsp_out_if.source out_ch,
  hrsp_cfg_if.sink   cfg
);
  import hrsp_pkg::*;

  logic [11:0]  header_limit;
  item_t        in_item;
  item_t        q_item;
  logic         q_valid;
  logic         q_ready;
  result_item_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= 12'd767;
    end else if (cfg.valid && cfg.ready) begin
      header_limit <= cfg.data;
    end
  end

  assign in_item.action  = action_t'(in_ch.action);
  assign in_item.rx_byte = in_ch.rx_byte;

  hrsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  hrsp_back #(.HEADER_COUNT_WIDTH(HEADER_COUNT_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .header_limit (header_limit),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_item      (q_item),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_item     (res)
  );

  assign out_ch.result_code     = res.result_code;
  assign out_ch.body_byte       = res.body_byte;
  assign out_ch.http_status     = res.http_status;
  assign out_ch.body_length     = res.body_length;
  assign out_ch.has_range       = res.has_range;
  assign out_ch.range_first     = res.range_first;
  assign out_ch.range_last      = res.range_last;
  assign out_ch.range_size      = res.range_size;
  assign out_ch.bytes_delivered = res.bytes_delivered;
endmodule
`default_nettype wire

### design/hrsp_checker.sv
// ----------------------------------------------------------------------------
// Parser port checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module hrsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  result_code,
  input wire logic [7:0]  body_byte,
  input wire logic [31:0] bytes_delivered,
  input wire logic [31:0] body_length
);
  import hrsp_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_code))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_code <= RC_IGNORED)
    else $error("undefined result code");

  a_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_code != RC_BODY && result_code != RC_DONE |-> body_byte == 8'd0)
    else $error("body byte outside body");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_code == RC_BODY |-> bytes_delivered != body_length)
    else $error("body byte at full count");
endmodule

bind http_response_stream_parser hrsp_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .result_code     (out_ch.result_code),
  .body_byte       (out_ch.body_byte),
  .bytes_delivered (out_ch.bytes_delivered),
  .body_length     (out_ch.body_length)
);
`default_nettype wire
